### hdl/rfd_pkg.sv
// shared constants, register indexes and types for the radar frame deframer
package rfd_pkg;

	// largest frame kept, header and tail included
	localparam int MAX_FRAME_BYTES = 128;

	// byte position inside a frame; never exceeds the frame limit
	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W = 16;
	localparam int TOT_W = LEN_W + 1;

	// fixed frame layout
	localparam int HDR_BYTES   = 4;
	localparam int FRAME_OVHD  = 10;
	localparam int MIN_ACK_TOT = 12;
	localparam int RES_HDR     = 4;
	localparam logic [15:0] MATCH_MASK = 16'h0100;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_HEADER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_HEADER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TRAILER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_TRAILER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_OPCODE   = 3'd4;

	// register reset values
	localparam logic [31:0] RST_ACK_HEADER   = 32'hFAFBFCFD;
	localparam logic [31:0] RST_DATA_HEADER  = 32'hF4F3F2F1;
	localparam logic [31:0] RST_ACK_TRAILER  = 32'h01020304;
	localparam logic [31:0] RST_DATA_TRAILER = 32'hF8F7F6F5;
	localparam logic [15:0] RST_EXP_OPCODE   = 16'h0000;

	// frame kinds
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// configuration as seen by the parser
	typedef struct packed {
		logic [31:0] ack_header;
		logic [31:0] data_header;
		logic [31:0] ack_trailer;
		logic [31:0] data_trailer;
		logic [15:0] expected_opcode;
	} rfd_cfg_t;

	// one decoded frame
	typedef struct packed {
		logic        frame_kind;
		logic [6:0]  body_length;
		logic [15:0] ack_code;
		logic [15:0] return_status;
		logic        command_ok;
		logic        ack_matches;
		logic [6:0]  result_bytes;
		logic [31:0] first_payload_word;
	} rfd_result_t;

endpackage

### hdl/rfd_parser.sv
// byte-wise frame parser: header hunt, length check, field capture and tail check
module rfd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  logic [7:0]          rx_byte,
	input  rfd_pkg::rfd_cfg_t   cfg,
	output logic                res_valid,
	output rfd_pkg::rfd_result_t res
);
	import rfd_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d, pos_inc;
	logic             is_ack_q, is_ack_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [15:0]      opcode_q, opcode_d;
	logic [15:0]      status_q, status_d;
	logic [31:0]      payload_q, payload_d;
	logic [31:0]      last4_q, last4_d;

	logic [31:0]      hdr_sel;
	logic [7:0]       hdr_byte;
	logic [TOT_W-1:0] total;
	logic [LEN_W-1:0] rlen_cur, rlen_new;
	logic [1:0]       pay_idx;
	logic             emit;

	// header byte expected at the current position
	assign hdr_sel  = is_ack_q ? cfg.ack_header : cfg.data_header;
	assign hdr_byte = hdr_sel[{pos_q[1:0], 3'b000} +: 8];
	assign pos_inc  = pos_q + POS_W'(1);
	assign pay_idx  = 2'(pos_q - POS_W'(FRAME_OVHD));
	assign rlen_cur = (len_q >= LEN_W'(RES_HDR)) ? len_q - LEN_W'(RES_HDR) : '0;
	assign rlen_new = (len_d >= LEN_W'(RES_HDR)) ? len_d - LEN_W'(RES_HDR) : '0;
	assign total    = TOT_W'(FRAME_OVHD) + TOT_W'(len_d);

	// next state for one received byte
	always_comb begin
		pos_d     = pos_q;
		is_ack_d  = is_ack_q;
		len_d     = len_q;
		opcode_d  = opcode_q;
		status_d  = status_q;
		payload_d = payload_q;
		last4_d   = {rx_byte, last4_q[31:8]};
		emit      = 1'b0;
		if (pos_q == '0 || (pos_q < POS_W'(HDR_BYTES) && rx_byte != hdr_byte)) begin
			// hunt: this byte may start either header, ack first
			pos_d = '0;
			if (rx_byte == cfg.ack_header[7:0]) begin
				is_ack_d = 1'b1;
				pos_d    = POS_W'(1);
			end else if (rx_byte == cfg.data_header[7:0]) begin
				is_ack_d = 1'b0;
				pos_d    = POS_W'(1);
			end
		end else if (pos_q < POS_W'(HDR_BYTES)) begin
			pos_d = pos_inc;
		end else begin
			// body byte capture by position
			if (pos_q == POS_W'(4)) begin
				len_d     = LEN_W'(rx_byte);
				opcode_d  = '0;
				status_d  = '0;
				payload_d = '0;
			end else if (pos_q == POS_W'(5)) begin
				len_d = {rx_byte, len_q[7:0]};
			end else if (pos_q == POS_W'(6)) begin
				opcode_d = {8'h00, rx_byte};
			end else if (pos_q == POS_W'(7)) begin
				opcode_d = {rx_byte, opcode_q[7:0]};
			end else if (pos_q == POS_W'(8)) begin
				status_d = {8'h00, rx_byte};
			end else if (pos_q == POS_W'(9)) begin
				status_d = {rx_byte, status_q[7:0]};
			end else if (pos_q < POS_W'(14)) begin
				if (LEN_W'(pay_idx) < rlen_cur)
					payload_d = payload_q | (32'(rx_byte) << {pay_idx, 3'b000});
			end
			pos_d = pos_inc;
			// length limit and frame end
			if (pos_inc >= POS_W'(6)) begin
				if (total > TOT_W'(MAX_FRAME_BYTES)) begin
					pos_d = '0;
				end else if (TOT_W'(pos_inc) >= total) begin
					pos_d = '0;
					if (is_ack_q) begin
						emit = (last4_d == cfg.ack_trailer) &&
							(total >= TOT_W'(MIN_ACK_TOT));
					end else begin
						emit = (last4_d == cfg.data_trailer);
					end
				end
			end
		end
	end

	// result fields from the updated capture
	always_comb begin
		res.frame_kind  = is_ack_q ? KIND_ACK : KIND_DATA;
		res.body_length = len_d[6:0];
		if (is_ack_q) begin
			res.ack_code           = opcode_d;
			res.return_status      = status_d;
			res.command_ok         = (status_d == '0);
			res.ack_matches        = (opcode_d == (cfg.expected_opcode | MATCH_MASK));
			res.result_bytes       = rlen_new[6:0];
			res.first_payload_word = payload_d;
		end else begin
			res.ack_code           = '0;
			res.return_status      = '0;
			res.command_ok         = 1'b0;
			res.ack_matches        = 1'b0;
			res.result_bytes       = '0;
			res.first_payload_word = '0;
		end
	end

	assign res_valid = byte_en && emit;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			is_ack_q  <= 1'b0;
			len_q     <= '0;
			opcode_q  <= '0;
			status_q  <= '0;
			payload_q <= '0;
			last4_q   <= '0;
		end else if (byte_en) begin
			pos_q     <= pos_d;
			is_ack_q  <= is_ack_d;
			len_q     <= len_d;
			opcode_q  <= opcode_d;
			status_q  <= status_d;
			payload_q <= payload_d;
			last4_q   <= last4_d;
		end
	end

endmodule

### hdl/radar_frame_deframer.sv
// radar frame deframer top level: configuration registers and result register
//
// Bytes from the sensor link enter on the s_ group, one per request. The block
// hunts for the ack or data header, reads the 16-bit little-endian length,
// drops frames over the size limit and checks the tail at the frame end.
// Each good frame gives one request on the m_ group: an ack frame carries its
// opcode, status, payload count and first payload word, a data frame only
// its kind (m_tuser) and length.
// The result is registered onto m_tvalid the cycle after the last tail byte
// is taken. Throughput: one byte per cycle while s_tready is high, set by the
// single parser stage between the input handshake and the result register.
// Header patterns, tails and the expected opcode are written on the cfg_
// port; the user must write them only while no frame is in flight, which the
// block does not enforce. Writes take effect at the next edge. Reset clears
// the parser to hunting, loads the default patterns and empties the result
// register. When the receiver stalls, the result register holds and input
// waits; s_tready drops only while a held result waits and m_tready is low.
module radar_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [79:0]                   m_tdata,   // [6:0] body_length,
	                                                 // [22:7] ack_code,
	                                                 // [38:23] return_status,
	                                                 // [39] command_ok,
	                                                 // [40] ack_matches,
	                                                 // [47:41] result_bytes,
	                                                 // [79:48] first_payload_word
	output logic                          m_tuser,   // [0] frame_kind
	input  logic                          cfg_we,
	input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_wdata
);
	import rfd_pkg::*;

	rfd_cfg_t    cfg_q;
	rfd_result_t res, res_q;
	logic        res_valid;
	logic        out_valid_q;
	logic        in_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_header      <= RST_ACK_HEADER;
			cfg_q.data_header     <= RST_DATA_HEADER;
			cfg_q.ack_trailer     <= RST_ACK_TRAILER;
			cfg_q.data_trailer    <= RST_DATA_TRAILER;
			cfg_q.expected_opcode <= RST_EXP_OPCODE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACK_HEADER:   cfg_q.ack_header      <= cfg_wdata;
				REG_DATA_HEADER:  cfg_q.data_header     <= cfg_wdata;
				REG_ACK_TRAILER:  cfg_q.ack_trailer     <= cfg_wdata;
				REG_DATA_TRAILER: cfg_q.data_trailer    <= cfg_wdata;
				REG_EXP_OPCODE:   cfg_q.expected_opcode <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// input taken whenever the result register is free or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign in_take  = s_tvalid && s_tready;

	rfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (in_take),
		.rx_byte   (s_tdata),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= res_valid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.frame_kind;
	assign m_tdata  = {res_q.first_payload_word, res_q.result_bytes, res_q.ack_matches,
		res_q.command_ok, res_q.return_status, res_q.ack_code, res_q.body_length};

endmodule
